@@ design/wms_pkg.sv @@
// shared types and constants of the wheel motor supervisor
package wms_pkg;

    // input function codes
    typedef enum logic [1:0] {
        FN_TICK = 2'd0,
        FN_ODO  = 2'd1,
        FN_CMD  = 2'd2,
        FN_UPD  = 2'd3
    } t_func;

    // register indexes of the configuration port
    localparam logic [2:0] REG_THRESH  = 3'd0;
    localparam logic [2:0] REG_TPR     = 3'd1;
    localparam logic [2:0] REG_CIRC    = 3'd2;
    localparam logic [2:0] REG_DIRHI   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_HOLD    = 3'd5;
    localparam logic [2:0] REG_PERIOD  = 3'd6;

    localparam logic [15:0] RST_THRESH  = 16'd3000;
    localparam logic [15:0] RST_TPR     = 16'd320;
    localparam logic [15:0] RST_CIRC    = 16'd785;
    localparam logic [15:0] RST_TIMEOUT = 16'd3000;
    localparam logic [15:0] RST_HOLD    = 16'd2000;
    localparam logic [15:0] RST_PERIOD  = 16'd100;

    localparam logic [15:0] MS_PER_MIN  = 16'd60000;
    localparam logic [9:0]  MS_PER_S    = 10'd1000;
    localparam logic [31:0] CALC_MIN_MS = 32'd10;
    localparam logic [31:0] SPIKE_MS    = 32'd1;
    localparam logic [15:0] SAT16       = 16'hFFFF;
    localparam logic [4:0]  DIV_STEPS   = 5'd16;

    // configuration seen by the datapath
    typedef struct packed {
        logic [15:0] thresh;
        logic [15:0] tpr;
        logic [15:0] circ;
        logic        dir_hi;
        logic [15:0] timeout;
        logic [15:0] hold;
        logic [15:0] period;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic mul1;
        logic mul2;
        logic div_step;
        logic div_next;
        logic div_fin;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic calc;
        logic div_last;
    } t_sts;

endpackage

@@ design/wms_cfg.sv @@
// apb configuration registers
module wms_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output wms_pkg::t_cfg o_cfg
);
    import wms_pkg::*;

    t_cfg        r_cfg;
    logic        w_wr;
    logic [2:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh  <= RST_THRESH;
            r_cfg.tpr     <= RST_TPR;
            r_cfg.circ    <= RST_CIRC;
            r_cfg.dir_hi  <= 1'b1;
            r_cfg.timeout <= RST_TIMEOUT;
            r_cfg.hold    <= RST_HOLD;
            r_cfg.period  <= RST_PERIOD;
        end else if (w_wr) begin
            case (w_idx)
                REG_THRESH:  r_cfg.thresh  <= pwdata[15:0];
                REG_TPR:     r_cfg.tpr     <= pwdata[15:0];
                REG_CIRC:    r_cfg.circ    <= pwdata[15:0];
                REG_DIRHI:   r_cfg.dir_hi  <= pwdata[0];
                REG_TIMEOUT: r_cfg.timeout <= pwdata[15:0];
                REG_HOLD:    r_cfg.hold    <= pwdata[15:0];
                REG_PERIOD:  r_cfg.period  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_THRESH:  prdata = {16'd0, r_cfg.thresh};
            REG_TPR:     prdata = {16'd0, r_cfg.tpr};
            REG_CIRC:    prdata = {16'd0, r_cfg.circ};
            REG_DIRHI:   prdata = {31'd0, r_cfg.dir_hi};
            REG_TIMEOUT: prdata = {16'd0, r_cfg.timeout};
            REG_HOLD:    prdata = {16'd0, r_cfg.hold};
            REG_PERIOD:  prdata = {16'd0, r_cfg.period};
            default:     prdata = 32'd0;
        endcase
    end
endmodule

@@ design/wms_dp.sv @@
// datapath: supervisor state, speed multipliers, shared divider, result registers
module wms_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wms_pkg::t_cfg i_cfg,
    input  wms_pkg::t_cmd i_cmd,
    output wms_pkg::t_sts o_sts,
    input  logic [1:0]    i_func,
    input  logic [8:0]    i_set_point,
    input  logic [15:0]   i_current_ma,
    output logic [15:0]   o_pwm_duty,
    output logic          o_dir_level,
    output logic          o_overload,
    output logic          o_command_taken,
    output logic [15:0]   o_rpm,
    output logic [15:0]   o_speed_mm_s
);
    import wms_pkg::*;

    // latched transaction
    t_func              r_func;
    logic signed [8:0]  r_sp;
    logic [15:0]        r_cur;

    // supervisor state
    logic [31:0] r_time, r_pc, r_pcl, r_swe, r_dl, r_due, r_hold, r_lct;
    logic        r_ovl, r_fwd, r_taken;
    logic [15:0] r_lat, r_duty, r_rpm, r_spd;
    logic signed [8:0] r_asp;

    // speed calculation
    logic [31:0] r_delta, r_ticks;
    logic [47:0] r_den, r_n1;
    logic [25:0] r_k;
    logic [57:0] r_n2;
    logic [63:0] r_rem, r_dsh;
    logic [16:0] r_q;
    logic [4:0]  r_cnt;

    // next values of the state
    logic [31:0] n_time, n_pc, n_pcl, n_swe, n_dl, n_due, n_hold, n_lct, n_delta, n_ticks;
    logic        n_ovl, n_fwd, n_taken;
    logic [15:0] n_lat, n_duty;
    logic signed [8:0] n_asp;

    logic [31:0] w_d_dl, w_d_due, w_d_hold, w_d_swe, w_delta;
    logic [8:0]  w_mag;
    logic [16:0] w_duty_full;
    logic [15:0] w_cur_eff;
    logic        w_calc, w_reverse, w_sample;

    // divider step
    logic [63:0] w_rem_sub;
    logic        w_ge;
    logic [16:0] w_q_next;
    logic [15:0] w_q_sat;

    assign w_d_dl   = r_dl - r_time;
    assign w_d_due  = r_due - r_time;
    assign w_d_hold = r_time - r_hold;
    assign w_d_swe  = r_time - r_swe;
    assign w_delta  = r_time - r_lct;
    assign w_calc   = (r_func == FN_UPD) && (w_delta > CALC_MIN_MS);
    assign w_sample = w_d_due[31];
    assign w_cur_eff = w_sample ? r_cur : r_lat;
    assign w_reverse = (r_asp < 0 && r_sp > 0) || (r_asp > 0 && r_sp < 0);
    assign w_mag = r_sp[8] ? 9'(-r_sp) : 9'(r_sp);
    // 65535 / 255 is exactly 257
    assign w_duty_full = {w_mag, 8'd0} + {8'd0, w_mag};

    // transaction execution
    always_comb begin
        n_time = r_time; n_pc = r_pc; n_pcl = r_pcl; n_swe = r_swe;
        n_dl = r_dl; n_due = r_due; n_hold = r_hold; n_lct = r_lct;
        n_ovl = r_ovl; n_fwd = r_fwd; n_taken = 1'b0;
        n_lat = r_lat; n_duty = r_duty; n_asp = r_asp;
        n_delta = r_delta; n_ticks = r_ticks;
        case (r_func)
            FN_TICK: n_time = r_time + 32'd1;
            FN_ODO: begin
                if (!w_d_swe[31]) begin
                    n_swe = r_time + SPIKE_MS;
                    n_pc  = r_pc + 32'd1;
                end
            end
            FN_CMD: begin
                n_dl = r_time + {16'd0, i_cfg.timeout};
                if (!(r_ovl && w_d_hold[31])) begin
                    n_taken = 1'b1;
                    if (w_reverse) begin
                        n_fwd  = ~r_fwd;
                        n_asp  = '0;
                        n_duty = '0;
                    end else begin
                        n_fwd  = ~r_sp[8];
                        n_asp  = r_sp;
                        n_duty = w_duty_full[16] ? SAT16 : w_duty_full[15:0];
                    end
                end
            end
            default: begin
                // watchdog
                if (w_d_dl[31]) begin
                    n_asp  = '0;
                    n_duty = '0;
                end
                if (w_sample) begin
                    n_lat = r_cur;
                    n_due = r_time + {16'd0, i_cfg.period};
                end
                if (w_cur_eff > i_cfg.thresh) begin
                    n_ovl  = 1'b1;
                    n_asp  = '0;
                    n_duty = '0;
                    n_hold = r_time + {16'd0, i_cfg.hold};
                end else begin
                    n_ovl = 1'b0;
                end
                if (w_calc) begin
                    n_ticks = r_pc - r_pcl;
                    n_delta = w_delta;
                    n_pcl   = r_pc;
                    n_lct   = r_time;
                end
            end
        endcase
    end

    assign w_rem_sub = r_rem - r_dsh;
    assign w_ge      = r_rem >= r_dsh;
    assign w_q_next  = {r_q[15:0], w_ge};
    assign w_q_sat   = w_q_next[16] ? SAT16 : w_q_next[15:0];

    assign o_sts.calc     = w_calc;
    assign o_sts.div_last = (r_cnt == 5'd0);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0; r_pc <= '0; r_pcl <= '0; r_swe <= '0;
            r_dl <= '0; r_due <= '0; r_hold <= '0; r_lct <= '0;
            r_ovl <= 1'b0; r_fwd <= 1'b1; r_taken <= 1'b0;
            r_lat <= '0; r_duty <= '0; r_asp <= '0;
            r_rpm <= '0; r_spd <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_time <= n_time; r_pc <= n_pc; r_pcl <= n_pcl; r_swe <= n_swe;
                r_dl <= n_dl; r_due <= n_due; r_hold <= n_hold; r_lct <= n_lct;
                r_ovl <= n_ovl; r_fwd <= n_fwd; r_taken <= n_taken;
                r_lat <= n_lat; r_duty <= n_duty; r_asp <= n_asp;
            end
            if (i_cmd.div_next) r_rpm <= w_q_sat;
            if (i_cmd.div_fin)  r_spd <= w_q_sat;
        end
    end

    // input latch and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_sp   <= i_set_point;
            r_cur  <= i_current_ma;
        end
        if (i_cmd.exec) begin
            r_delta <= n_delta;
            r_ticks <= n_ticks;
        end
        if (i_cmd.mul1) begin
            r_den <= 48'(i_cfg.tpr == 16'd0 ? 16'd1 : i_cfg.tpr) * 48'(r_delta);
            r_n1  <= 48'(MS_PER_MIN) * 48'(r_ticks);
            r_k   <= 26'(MS_PER_S) * 26'(i_cfg.circ);
        end
        if (i_cmd.mul2) begin
            r_n2  <= 58'(r_k) * 58'(r_ticks);
            r_rem <= {16'd0, r_n1};
            r_dsh <= {r_den, 16'd0};
            r_q   <= '0;
            r_cnt <= DIV_STEPS;
        end else if (i_cmd.div_next) begin
            r_rem <= {6'd0, r_n2};
            r_dsh <= {r_den, 16'd0};
            r_q   <= '0;
            r_cnt <= DIV_STEPS;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub : r_rem;
            r_dsh <= {1'b0, r_dsh[63:1]};
            r_q   <= w_q_next;
            r_cnt <= r_cnt - 5'd1;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_pwm_duty      <= r_duty;
            o_dir_level     <= r_fwd ? i_cfg.dir_hi : ~i_cfg.dir_hi;
            o_overload      <= r_ovl;
            o_command_taken <= r_taken;
            o_rpm           <= r_rpm;
            o_speed_mm_s    <= r_spd;
        end
    end
endmodule

@@ design/wms_ctrl.sv @@
// controller: sequences execution, multiplies and divisions, owns both handshakes
module wms_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  wms_pkg::t_sts i_sts,
    output wms_pkg::t_cmd o_cmd
);
    import wms_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_EXEC = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_MUL2 = 7'b0001000,
        ST_DRPM = 7'b0010000,
        ST_DSPD = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_free;

    assign w_free      = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.exec     = (r_state == ST_EXEC);
        o_cmd.mul1     = (r_state == ST_MUL);
        o_cmd.mul2     = (r_state == ST_MUL2);
        o_cmd.div_step = (r_state == ST_DRPM) || (r_state == ST_DSPD);
        o_cmd.div_next = (r_state == ST_DRPM) && i_sts.div_last;
        o_cmd.div_fin  = (r_state == ST_DSPD) && i_sts.div_last;
        o_cmd.emit     = (r_state == ST_DONE) && w_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC: n_state = i_sts.calc ? ST_MUL : ST_DONE;
            ST_MUL:  n_state = ST_MUL2;
            ST_MUL2: n_state = ST_DRPM;
            ST_DRPM: if (i_sts.div_last) n_state = ST_DSPD;
            ST_DSPD: if (i_sts.div_last) n_state = ST_DONE;
            ST_DONE: if (w_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end
endmodule

@@ design/wheel_motor_supervisor_top.sv @@
// top level of the wheel motor supervisor
//
//   port group     direction  handshake
//   input item     in         i_in_valid / o_in_ready
//   result item    out        o_out_valid / i_out_ready
//   configuration  in/out     apb psel / penable, pready always high
//
// a transaction with no speed calculation due passes through accept, execute and emit
// a control update that triggers rpm and mm/s runs through the multiply states ST_MUL and
// ST_MUL2 and two 17-step restoring divisions on the one shared divider
// reset is synchronous and active low; no clearing pass is needed
// a new item is accepted while a finished result waits; a stalled output holds the
// controller in its emit state

module wheel_motor_supervisor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [8:0]  i_set_point,
    input  logic [15:0] i_current_ma,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_pwm_duty,
    output logic        o_dir_level,
    output logic        o_overload,
    output logic        o_command_taken,
    output logic [15:0] o_rpm,
    output logic [15:0] o_speed_mm_s,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wms_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    wms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    wms_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_func          (i_func),
        .i_set_point     (i_set_point),
        .i_current_ma    (i_current_ma),
        .o_pwm_duty      (o_pwm_duty),
        .o_dir_level     (o_dir_level),
        .o_overload      (o_overload),
        .o_command_taken (o_command_taken),
        .o_rpm           (o_rpm),
        .o_speed_mm_s    (o_speed_mm_s)
    );

    // one item in flight: an accepted transaction blocks the next one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !o_out_valid || i_out_ready)
        else $error("result overwritten");

    // divider runs only while no item can enter
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_step |-> !o_in_ready && !w_cmd.emit)
        else $error("divider active outside calculation");
endmodule

@@ verif/wheel_motor_supervisor_top_test.sv @@
// self-checking testbench of the wheel motor supervisor top level
`timescale 1ns / 1ps

module wheel_motor_supervisor_top_test;
    import wms_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int DRAIN_CYCLES = 100;

    // one result transaction
    typedef struct packed {
        logic [15:0] pwm_duty;
        logic        dir_level;
        logic        overload;
        logic        command_taken;
        logic [15:0] rpm;
        logic [15:0] speed_mm_s;
    } t_result;

    // one directed stimulus row; check_now marks a typed-in expectation
    typedef struct {
        t_func       func;
        logic [8:0]  set_point;
        logic [15:0] current_ma;
        bit          check_now;
        t_result     want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [8:0]  i_set_point;
    logic [15:0] i_current_ma;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_pwm_duty;
    logic        o_dir_level;
    logic        o_overload;
    logic        o_command_taken;
    logic [15:0] o_rpm;
    logic [15:0] o_speed_mm_s;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wheel_motor_supervisor_top dut (.*);

    // shadow configuration
    logic [15:0] cfg_thresh, cfg_tpr, cfg_circ, cfg_timeout, cfg_hold, cfg_period;
    logic        cfg_dir_hi;

    // shadow supervisor state
    logic [31:0] sh_time, sh_pulses, sh_pulses_calc, sh_spike_end, sh_deadline;
    logic [31:0] sh_sample_due, sh_hold_end, sh_calc_time;
    logic        sh_overload, sh_forward;
    logic [15:0] sh_latched, sh_duty, sh_rpm, sh_speed;
    logic signed [8:0] sh_set_point;

    t_result expected_results[$];
    int      error_count;
    int      send_idle_pct;
    int      recv_idle_pct;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic bit ms_before(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic [15:0] clip16(logic [63:0] v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic reset_shadow();
        cfg_thresh = RST_THRESH;
        cfg_tpr = RST_TPR;
        cfg_circ = RST_CIRC;
        cfg_dir_hi = 1'b1;
        cfg_timeout = RST_TIMEOUT;
        cfg_hold = RST_HOLD;
        cfg_period = RST_PERIOD;
        sh_time = '0; sh_pulses = '0; sh_pulses_calc = '0; sh_spike_end = '0;
        sh_deadline = '0; sh_sample_due = '0; sh_hold_end = '0; sh_calc_time = '0;
        sh_overload = 1'b0; sh_forward = 1'b1; sh_latched = '0; sh_duty = '0;
        sh_rpm = '0; sh_speed = '0; sh_set_point = '0;
    endtask

    // predicts the result of one input transaction and advances the shadow state
    function automatic t_result supervise(t_func func, logic [8:0] sp_raw,
                                          logic [15:0] cur);
        t_result r;
        logic signed [8:0] sp;
        logic [31:0] mag, duty, delta;
        logic [63:0] ticks, den;
        bit taken;
        sp = sp_raw;
        taken = 1'b0;
        case (func)
            FN_TICK: sh_time = sh_time + 1;
            FN_ODO: begin
                if (!ms_before(sh_time, sh_spike_end)) begin
                    sh_spike_end = sh_time + SPIKE_MS;
                    sh_pulses = sh_pulses + 1;
                end
            end
            FN_CMD: begin
                sh_deadline = sh_time + cfg_timeout;
                if (!(sh_overload && ms_before(sh_time, sh_hold_end))) begin
                    taken = 1'b1;
                    if ((sh_set_point < 0 && sp > 0) || (sh_set_point > 0 && sp < 0)) begin
                        sh_forward = ~sh_forward;
                        sh_set_point = '0;
                        sh_duty = '0;
                    end else begin
                        sh_forward = (sp >= 0);
                        sh_set_point = sp;
                        mag = (sp < 0) ? 32'(-32'(sp)) : 32'(sp);
                        duty = (mag * 32'd65535) / 32'd255;
                        sh_duty = (duty > 32'd65535) ? 16'hFFFF : duty[15:0];
                    end
                end
            end
            default: begin
                if (ms_before(sh_deadline, sh_time)) begin
                    sh_set_point = '0;
                    sh_duty = '0;
                end
                if (ms_before(sh_sample_due, sh_time)) begin
                    sh_latched = cur;
                    sh_sample_due = sh_time + cfg_period;
                end
                if (sh_latched > cfg_thresh) begin
                    sh_overload = 1'b1;
                    sh_set_point = '0;
                    sh_duty = '0;
                    sh_hold_end = sh_time + cfg_hold;
                end else begin
                    sh_overload = 1'b0;
                end
                delta = sh_time - sh_calc_time;
                if (delta > CALC_MIN_MS) begin
                    ticks = 64'(sh_pulses - sh_pulses_calc);
                    den = 64'((cfg_tpr == 0) ? 16'd1 : cfg_tpr) * 64'(delta);
                    sh_pulses_calc = sh_pulses;
                    sh_rpm = clip16((64'd60000 * ticks) / den);
                    sh_speed = clip16((64'd1000 * 64'(cfg_circ) * ticks) / den);
                    sh_calc_time = sh_time;
                end
            end
        endcase
        r.pwm_duty = sh_duty;
        r.dir_level = sh_forward ? cfg_dir_hi : ~cfg_dir_hi;
        r.overload = sh_overload;
        r.command_taken = taken;
        r.rpm = sh_rpm;
        r.speed_mm_s = sh_speed;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // register write over apb, setup then access
    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_THRESH:  cfg_thresh = value;
            REG_TPR:     cfg_tpr = value;
            REG_CIRC:    cfg_circ = value;
            REG_DIRHI:   cfg_dir_hi = value[0];
            REG_TIMEOUT: cfg_timeout = value;
            REG_HOLD:    cfg_hold = value;
            REG_PERIOD:  cfg_period = value;
            default:     ;
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // drives one input transaction, holding valid until accepted
    task automatic send_item(t_func func, logic [8:0] sp, logic [15:0] cur);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_set_point <= sp;
        i_current_ma <= cur;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(supervise(func, sp, cur));
        @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        int k;
        int pick;
        t_func f;
        logic [15:0] cur;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99, 0);
            if (pick < 45) f = FN_TICK;
            else if (pick < 65) f = FN_ODO;
            else if (pick < 80) f = FN_CMD;
            else f = FN_UPD;
            // mostly moderate currents around threshold, sometimes any value
            cur = ($urandom_range(3, 0) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(4000, 0));
            send_item(f, 9'($urandom), cur);
        end
    endtask

    // receiver side stalls
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // result checking
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_pwm_duty !== want.pwm_duty)
                    report_mismatch("pwm_duty", o_pwm_duty, want.pwm_duty);
                if (o_dir_level !== want.dir_level)
                    report_mismatch("dir_level", o_dir_level, want.dir_level);
                if (o_overload !== want.overload)
                    report_mismatch("overload", o_overload, want.overload);
                if (o_command_taken !== want.command_taken)
                    report_mismatch("command_taken", o_command_taken, want.command_taken);
                if (o_rpm !== want.rpm)
                    report_mismatch("rpm", o_rpm, want.rpm);
                if (o_speed_mm_s !== want.speed_mm_s)
                    report_mismatch("speed_mm_s", o_speed_mm_s, want.speed_mm_s);
            end
        end
    end

    // run time limit
    initial begin
        #(CLK_PERIOD * 2000000);
        $display("wheel_motor_supervisor_top: mismatch");
        $finish;
    end

    // main sequence
    initial begin
        t_row rows[$];
        t_row row;
        t_result typed;
        t_result got;
        int n;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = FN_TICK;
        i_set_point = '0;
        i_current_ma = '0;
        i_out_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0;
        send_idle_pct = 9;
        recv_idle_pct = 64;
        reset_shadow();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        typed = '{16'd0, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0};
        rows.push_back('{FN_UPD, 9'd0, 16'd0, 1'b1, typed});     // state after reset
        typed = '{16'hFFFF, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0};
        rows.push_back('{FN_CMD, 9'd255, 16'd0, 1'b1, typed});   // full forward
        rows.push_back('{FN_CMD, 9'h1FF, 16'd0, 1'b0, typed});   // sign reversal stop
        rows.push_back('{FN_CMD, 9'h100, 16'd0, 1'b0, typed});   // -256 saturates
        rows.push_back('{FN_CMD, 9'd0, 16'd0, 1'b0, typed});
        rows.push_back('{FN_ODO, 9'd0, 16'd0, 1'b0, typed});
        rows.push_back('{FN_ODO, 9'd0, 16'd0, 1'b0, typed});     // spike window
        rows.push_back('{FN_TICK, 9'd0, 16'd0, 1'b0, typed});
        rows.push_back('{FN_ODO, 9'd0, 16'd0, 1'b0, typed});
        rows.push_back('{FN_TICK, 9'd0, 16'd0, 1'b0, typed});
        rows.push_back('{FN_ODO, 9'd0, 16'd0, 1'b0, typed});
        for (n = 0; n < 11; n++) rows.push_back('{FN_TICK, 9'd0, 16'd0, 1'b0, typed});
        rows.push_back('{FN_UPD, 9'd0, 16'hFFFF, 1'b0, typed});  // overload and calc
        rows.push_back('{FN_CMD, 9'd17, 16'd0, 1'b0, typed});    // refused in hold
        rows.push_back('{FN_UPD, 9'd0, 16'd0, 1'b0, typed});
        foreach (rows[i]) begin
            row = rows[i];
            if (row.check_now) begin
                got = supervise(row.func, row.set_point, row.current_ma);
                if (got != row.want) report_mismatch("table row", i, 0);
                reset_shadow();
            end
            send_item(row.func, row.set_point, row.current_ma);
        end
        drain();

        // extreme settings, short watchdog and period
        write_reg(REG_THRESH, 16'd0);
        write_reg(REG_TPR, 16'd1);
        write_reg(REG_CIRC, 16'hFFFF);
        write_reg(REG_DIRHI, 16'd0);
        write_reg(REG_TIMEOUT, 16'd1);
        write_reg(REG_HOLD, 16'd0);
        write_reg(REG_PERIOD, 16'd1);
        send_random(150);
        drain();

        // idling swapped, mid settings and zero ticks per revolution
        send_idle_pct = 64;
        recv_idle_pct = 9;
        write_reg(REG_THRESH, 16'd2000);
        write_reg(REG_TPR, 16'd0);
        write_reg(REG_CIRC, 16'd1);
        write_reg(REG_DIRHI, 16'd1);
        write_reg(REG_TIMEOUT, 16'd40);
        write_reg(REG_HOLD, 16'd30);
        write_reg(REG_PERIOD, 16'd5);
        send_random(200);
        // sender holds off until every result has come
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        send_random(50);
        drain();

        // no idling, top of every range except circ
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_THRESH, 16'hFFFF);
        write_reg(REG_TPR, 16'hFFFF);
        write_reg(REG_CIRC, 16'd785);
        write_reg(REG_TIMEOUT, 16'hFFFF);
        write_reg(REG_HOLD, 16'hFFFF);
        write_reg(REG_PERIOD, 16'hFFFF);
        send_random(125);
        drain();
        write_reg(REG_THRESH, 16'd1500);
        write_reg(REG_TPR, 16'd3);
        write_reg(REG_TIMEOUT, 16'd20);
        write_reg(REG_HOLD, 16'd10);
        write_reg(REG_PERIOD, 16'd3);
        send_random(200);
        drain();

        if (error_count == 0) begin
            $display("wheel_motor_supervisor_top: match");
        end else begin
            $display("wheel_motor_supervisor_top: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/wms_pkg.sv
design/wms_cfg.sv
design/wms_dp.sv
design/wms_ctrl.sv
design/wheel_motor_supervisor_top.sv
verif/wheel_motor_supervisor_top_test.sv
